// ===== src/sfd_pkg.sv =====
// Shared types and constants for the stereo feedback delay core.
// No dependencies; the files that use it refer to it by scoped names.
`default_nettype none

package sfd_pkg;

    // Default sizes, handed to the top-level parameters
    localparam int MAX_DELAY_DEF   = 32768;
    localparam int SAMPLE_BITS_DEF = 16;

    // Gain format: unsigned Q0.16
    localparam int GAIN_W = 16;

    // Wet path is active only above 0.01 in Q0.16, rounded down
    localparam logic [GAIN_W-1:0] MIX_THRESHOLD = 16'd655;

    // Config port geometry
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // Result queue depth
    localparam int FIFO_DEPTH = 4;

    // Register indexes on the config port
    typedef enum logic [1:0] {
        REG_MIX_GAIN      = 2'd0,
        REG_FEEDBACK_GAIN = 2'd1,
        REG_DELAY_SAMPLES = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0] mix_gain;
        logic [GAIN_W-1:0] feedback_gain;
        logic [15:0]       delay_samples;
    } cfg_t;

endpackage

`default_nettype wire

// ===== src/sfd_cfg_regs.sv =====
// APB-style configuration registers: mix gain, feedback gain, delay length.
// Depends on sfd_pkg (cfg_t, register indexes, port widths).
`default_nettype none

module sfd_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [sfd_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [sfd_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [sfd_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                  pready,
    output sfd_pkg::cfg_t                         cfg
);

    sfd_pkg::cfg_t cfg_reg;
    logic [1:0]    reg_idx;
    logic          wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mix_gain      <= '0;
            cfg_reg.feedback_gain <= '0;
            cfg_reg.delay_samples <= 16'd1;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                sfd_pkg::REG_MIX_GAIN:      cfg_reg.mix_gain      <= pwdata[15:0];
                sfd_pkg::REG_FEEDBACK_GAIN: cfg_reg.feedback_gain <= pwdata[15:0];
                sfd_pkg::REG_DELAY_SAMPLES: cfg_reg.delay_samples <= pwdata[15:0];
                default: ;  // unmapped slot, write dropped
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            sfd_pkg::REG_MIX_GAIN:      prdata = {16'd0, cfg_reg.mix_gain};
            sfd_pkg::REG_FEEDBACK_GAIN: prdata = {16'd0, cfg_reg.feedback_gain};
            sfd_pkg::REG_DELAY_SAMPLES: prdata = {16'd0, cfg_reg.delay_samples};
            default:                    prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/sfd_line_ram.sv =====
// Delay-line storage: simple dual-port synchronous RAM with a registered read.
// Read during a write to the same address returns the old word. No package use.
`default_nettype none

module sfd_line_ram #(
    parameter int AW = 16,
    parameter int DW = 16
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/sfd_out_fifo.sv =====
// Small result queue between the datapath and the output channel.
// Depends on sfd_pkg (FIFO_DEPTH). Caller guarantees no push when full.
`default_nettype none

module sfd_out_fifo #(
    parameter int DW = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire logic [DW-1:0] push_data,
    input  wire logic          pop,
    output logic               valid,
    output logic      [DW-1:0] data
);

    localparam int PW = $clog2(sfd_pkg::FIFO_DEPTH);
    localparam int CW = $clog2(sfd_pkg::FIFO_DEPTH + 1);

    logic [DW-1:0] slot_reg [sfd_pkg::FIFO_DEPTH];
    logic [PW-1:0] wptr_reg;
    logic [PW-1:0] rptr_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign valid = (count_reg != '0);
    assign data  = slot_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + PW'(1);
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/stereo_feedback_delay_core.sv =====
// Top level of the stereo feedback delay: pipeline, RAM, config and result queue.
// Depends on sfd_pkg, sfd_cfg_regs, sfd_line_ram and sfd_out_fifo.
//
//   port group   dir  handshake                     payload
//   ----------   ---  ----------------------------  ------------------------
//   cfg (APB)    in   psel & penable & pwrite       paddr, pwdata (prdata out)
//   in           in   in_valid & in_ready           in_sample, channel_sel
//   out          out  out_valid & out_ready         out_sample
//
// One request per cycle when the output drains, apart from the stall below; an accepted
// request passes the RAM read, the multiply and the sum, then enters the result queue.
// A same-channel request that reads the slot written by the request right
// before it (delay of one) stalls until that request leaves stage 1, so the write can be forwarded.
// Reset clears positions and fill flags at once; no RAM clearing pass is run.
// out_ready low fills the four-entry result queue, then in_ready drops.
`default_nettype none

module stereo_feedback_delay_core #(
    parameter int MAX_DELAY   = sfd_pkg::MAX_DELAY_DEF,
    parameter int SAMPLE_BITS = sfd_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // config port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [sfd_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [sfd_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [sfd_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                   pready,
    // sample requests
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]     in_sample,
    input  wire logic                              channel_sel,
    // results
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [SAMPLE_BITS-1:0]          out_sample
);

    localparam int ADDR_W = $clog2(MAX_DELAY);      // slot index within one line
    localparam int MEM_AW = ADDR_W + 1;             // {channel, slot}
    localparam int D_W    = ADDR_W + 1;             // holds MAX_DELAY itself
    localparam int PROD_W = SAMPLE_BITS + sfd_pkg::GAIN_W + 1;
    localparam int SUM_W  = SAMPLE_BITS + 2;
    localparam int OCC_W  = $clog2(sfd_pkg::FIFO_DEPTH + 1);

    localparam logic [D_W-1:0]    MAX_D     = D_W'(MAX_DELAY);
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(MAX_DELAY - 1);
    localparam logic signed [PROD_W-1:0] ROUND_C = PROD_W'(32'sd32768);
    localparam logic signed [SUM_W-1:0]  SAT_MAX = SUM_W'((64'sd1 <<< (SAMPLE_BITS-1)) - 1);
    localparam logic signed [SUM_W-1:0]  SAT_MIN = SUM_W'(-(64'sd1 <<< (SAMPLE_BITS-1)));

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SUM_W-1:0] c;
        c = v;
        if (v > SAT_MAX)
        begin
            c = SAT_MAX;
        end
        else if (v < SAT_MIN)
        begin
            c = SAT_MIN;
        end
        return c[SAMPLE_BITS-1:0];
    endfunction

    // ---------------- configuration ----------------
    sfd_pkg::cfg_t cfg;

    sfd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ---------------- per-channel write position and fill flag ----------------
    // A line slot has been written once its index is below the write position,
    // or once the line has wrapped. Unwritten slots read as zero.
    logic [ADDR_W-1:0] wpos_reg [2];
    logic              full_reg [2];

    // ---------------- accept stage ----------------
    logic              active;
    logic [31:0]       delay_ext;
    logic [31:0]       delay_clamp;
    logic [D_W-1:0]    d_eff;
    logic [ADDR_W-1:0] pos;
    logic [D_W-1:0]    pos_ext;
    logic [D_W-1:0]    rd_slot;
    logic [MEM_AW-1:0] rd_addr;
    logic [MEM_AW-1:0] wr_addr;
    logic              slot_written;
    logic              hazard;
    logic              in_accept;
    logic              out_accept;
    logic [OCC_W-1:0]  occ_reg;

    // stage 1 (RAM data arrives, multiply)
    logic                          s1_valid_reg;
    logic                          s1_active_reg;
    logic                          s1_written_reg;
    logic signed [SAMPLE_BITS-1:0] s1_x_reg;
    logic [MEM_AW-1:0]             s1_rd_addr_reg;
    logic [MEM_AW-1:0]             s1_waddr_reg;

    // stage 2 (round, sum, saturate, write back)
    logic                          s2_valid_reg;
    logic                          s2_active_reg;
    logic signed [SAMPLE_BITS-1:0] s2_x_reg;
    logic [MEM_AW-1:0]             s2_waddr_reg;
    logic signed [PROD_W-1:0]      s2_prod_mix_reg;
    logic signed [PROD_W-1:0]      s2_prod_fb_reg;
    logic signed [PROD_W-1:0]      s2_prod_mix_next;
    logic signed [PROD_W-1:0]      s2_prod_fb_next;

    // last write, registered at its edge for forwarding to a read issued at that edge
    logic                          last_wr_valid_reg;
    logic [MEM_AW-1:0]             last_wr_addr_reg;
    logic [SAMPLE_BITS-1:0]        last_wr_data_reg;

    logic [SAMPLE_BITS-1:0]        mem_rdata;
    logic                          mem_we;
    logic                          mem_re;
    logic signed [SAMPLE_BITS-1:0] delayed;
    logic signed [PROD_W-1:0]      rnd_mix;
    logic signed [PROD_W-1:0]      rnd_fb;
    logic signed [PROD_W-1:0]      scaled_mix;
    logic signed [PROD_W-1:0]      scaled_fb;
    logic signed [SUM_W-1:0]       sum_mix;
    logic signed [SUM_W-1:0]       sum_fb;
    logic signed [SAMPLE_BITS-1:0] y;
    logic signed [SAMPLE_BITS-1:0] fb;

    assign active = (cfg.mix_gain > sfd_pkg::MIX_THRESHOLD);

    // delay of zero acts as one, above the line length it saturates
    assign delay_ext = {16'd0, cfg.delay_samples};
    always_comb
    begin
        delay_clamp = delay_ext;
        if (delay_ext == 32'd0)
        begin
            delay_clamp = 32'd1;
        end
        else if (delay_ext > 32'(MAX_DELAY))
        begin
            delay_clamp = 32'(MAX_DELAY);
        end
    end
    assign d_eff = delay_clamp[D_W-1:0];

    assign pos     = wpos_reg[channel_sel];
    assign pos_ext = {1'b0, pos};

    always_comb
    begin
        if (pos_ext >= d_eff)
        begin
            rd_slot = pos_ext - d_eff;
        end
        else
        begin
            rd_slot = pos_ext + MAX_D - d_eff;
        end
    end

    assign rd_addr      = {channel_sel, rd_slot[ADDR_W-1:0]};
    assign wr_addr      = {channel_sel, pos};
    assign slot_written = full_reg[channel_sel] || (rd_slot[ADDR_W-1:0] < pos);

    // the previous request's write lands after this read is issued, too late to forward
    assign hazard = active && s1_valid_reg && s1_active_reg && (s1_waddr_reg == rd_addr);

    assign in_ready   = (occ_reg < OCC_W'(sfd_pkg::FIFO_DEPTH)) && !hazard;
    assign in_accept  = in_valid && in_ready;
    assign out_accept = out_valid && out_ready;
    assign mem_re     = in_accept && active;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg[0] <= '0;
            wpos_reg[1] <= '0;
            full_reg[0] <= 1'b0;
            full_reg[1] <= 1'b0;
            occ_reg     <= '0;
        end
        else
        begin
            if (in_accept && active)
            begin
                if (pos == LAST_SLOT)
                begin
                    wpos_reg[channel_sel] <= '0;
                    full_reg[channel_sel] <= 1'b1;
                end
                else
                begin
                    wpos_reg[channel_sel] <= pos + ADDR_W'(1);
                end
            end
            if (in_accept && !out_accept)
            begin
                occ_reg <= occ_reg + OCC_W'(1);
            end
            else if (out_accept && !in_accept)
            begin
                occ_reg <= occ_reg - OCC_W'(1);
            end
        end
    end

    // ---------------- delay-line RAM ----------------
    sfd_line_ram #(
        .AW (MEM_AW),
        .DW (SAMPLE_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (s2_waddr_reg),
        .wdata (fb),
        .re    (mem_re),
        .raddr (rd_addr),
        .rdata (mem_rdata)
    );

    // ---------------- stage 1: select delayed sample, multiply ----------------
    always_comb
    begin
        delayed = '0;
        if (last_wr_valid_reg && (last_wr_addr_reg == s1_rd_addr_reg))
        begin
            delayed = signed'(last_wr_data_reg);
        end
        else if (s1_written_reg)
        begin
            delayed = signed'(mem_rdata);
        end
    end

    assign s2_prod_mix_next = PROD_W'(delayed) * PROD_W'(signed'({1'b0, cfg.mix_gain}));
    assign s2_prod_fb_next  = PROD_W'(delayed) * PROD_W'(signed'({1'b0, cfg.feedback_gain}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            last_wr_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg      <= in_accept;
            s2_valid_reg      <= s1_valid_reg;
            last_wr_valid_reg <= mem_we;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_active_reg  <= active;
            s1_written_reg <= slot_written;
            s1_x_reg       <= in_sample;
            s1_rd_addr_reg <= rd_addr;
            s1_waddr_reg   <= wr_addr;
        end
        if (s1_valid_reg)
        begin
            s2_active_reg   <= s1_active_reg;
            s2_x_reg        <= s1_x_reg;
            s2_waddr_reg    <= s1_waddr_reg;
            s2_prod_mix_reg <= s2_prod_mix_next;
            s2_prod_fb_reg  <= s2_prod_fb_next;
        end
        if (mem_we)
        begin
            last_wr_addr_reg <= s2_waddr_reg;
            last_wr_data_reg <= fb;
        end
    end

    // ---------------- stage 2: round half up, add, saturate ----------------
    assign rnd_mix    = s2_prod_mix_reg + ROUND_C;
    assign rnd_fb     = s2_prod_fb_reg + ROUND_C;
    assign scaled_mix = rnd_mix >>> sfd_pkg::GAIN_W;
    assign scaled_fb  = rnd_fb >>> sfd_pkg::GAIN_W;
    assign sum_mix    = SUM_W'(s2_x_reg) + SUM_W'(scaled_mix);
    assign sum_fb     = SUM_W'(s2_x_reg) + SUM_W'(scaled_fb);
    assign fb         = sat_sample(sum_fb);
    assign y          = s2_active_reg ? sat_sample(sum_mix) : s2_x_reg;
    assign mem_we     = s2_valid_reg && s2_active_reg;

    // ---------------- result queue ----------------
    logic [SAMPLE_BITS-1:0] q_data;

    sfd_out_fifo #(
        .DW (SAMPLE_BITS)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s2_valid_reg),
        .push_data (y),
        .pop       (out_accept),
        .valid     (out_valid),
        .data      (q_data)
    );

    assign out_sample = signed'(q_data);

    // ---------------- assertions ----------------
    // A queued result always has a matching outstanding request.
    a_occ_covers_queue: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (occ_reg != '0))
        else $error("result queued with no outstanding request");

    // The interlock keeps the write-back off a read that is still in flight.
    a_no_late_write: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_active_reg) |-> !(mem_we && (s2_waddr_reg == s1_rd_addr_reg)))
        else $error("write to a slot whose read missed forwarding");

    // Read and write of one request stay in the same channel's line.
    a_same_line: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_active_reg) |->
            (s1_rd_addr_reg[ADDR_W] == s1_waddr_reg[ADDR_W]))
        else $error("read and write address in different lines");

    // Write-back only follows an active request from the previous stage.
    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> $past(s1_valid_reg && s1_active_reg))
        else $error("RAM write without an active request");

endmodule

`default_nettype wire

// ===== tb/stereo_feedback_delay_core_tb.sv =====
// Self-checking bench for stereo_feedback_delay_core: APB register writes and
// stereo sample requests, each output checked against an in-bench echo predictor.
// Depends on sfd_pkg and the core RTL; reads no files.
module stereo_feedback_delay_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DELAY      = sfd_pkg::MAX_DELAY_DEF;
    localparam int AW             = sfd_pkg::CFG_ADDR_W;
    localparam int DW             = sfd_pkg::CFG_DATA_W;
    localparam int UNUSED_REG     = 3;      // index past the last register
    localparam int DRAIN_CYCLES   = 8;      // core is three stages deep
    localparam int RANDOM_PHASES  = 15;
    localparam int PHASE_REQUESTS = 120;
    localparam int HOLD_CYCLES    = 300;
    localparam int FULL_REQUESTS  = 70;
    localparam longint SAMPLE_HI  = 32767;
    localparam longint SAMPLE_LO  = -32768;

    // ---------------------------------------------------------------- DUT
    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    psel        = 1'b0;
    logic                    penable     = 1'b0;
    logic                    pwrite      = 1'b0;
    logic [AW-1:0]           paddr       = '0;
    logic [DW-1:0]           pwdata      = '0;
    logic [DW-1:0]           prdata;
    logic                    pready;
    logic                    in_valid    = 1'b0;
    logic                    in_ready;
    logic signed [15:0]      in_sample   = '0;
    logic                    channel_sel = 1'b0;
    logic                    out_valid;
    logic                    out_ready   = 1'b0;
    logic signed [15:0]      out_sample;

    stereo_feedback_delay_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_sample   (in_sample),
        .channel_sel (channel_sel),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_sample  (out_sample)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------ echo predictor
    // Bench copy of both delay lines, write positions and registers.
    // Lines start at zero, same as the core after reset.
    bit signed [15:0]   echo_line [2][MAX_DELAY];
    int unsigned        line_pos [2];
    logic [15:0]        mix_gain_cfg      = 16'd0;
    logic [15:0]        feedback_gain_cfg = 16'd0;
    logic [15:0]        delay_cfg         = 16'd1;

    logic signed [15:0] expected_echo_q [$];
    logic signed [15:0] expected_out;

    int requests_sent  = 0;
    int echoes_checked = 0;
    int error_count    = 0;

    // Stall control
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_len      = 0;   // set by a test, picked up by the receiver
    int stall_left    = 0;

    // Q0.16 gain, round to nearest with ties up; >>> on longint floors
    function automatic longint scale_q16(longint x, longint g);
        return (x * g + 32768) >>> 16;
    endfunction

    function automatic logic signed [15:0] clip_sample(longint v);
        if (v > SAMPLE_HI)
            return 16'sh7fff;
        if (v < SAMPLE_LO)
            return 16'sh8000;
        return 16'(v);
    endfunction

    // One accepted request: returns the output and updates the line.
    function automatic logic signed [15:0] predict_echo(logic signed [15:0] x, logic chan);
        int unsigned        d;
        int unsigned        wr;
        int unsigned        rd;
        longint             delayed;
        logic signed [15:0] wet;
        // at or below the 0.01 threshold: dry pass, line untouched
        if (mix_gain_cfg <= sfd_pkg::MIX_THRESHOLD)
            return x;
        // zero delay acts as one, too long clamps to full line length
        d = delay_cfg;
        if (d < 1)
            d = 1;
        if (d > MAX_DELAY)
            d = MAX_DELAY;
        wr = line_pos[chan];
        // full-length delay reads the slot about to be overwritten
        rd = (wr + MAX_DELAY - d) % MAX_DELAY;
        delayed = echo_line[chan][rd];
        wet = clip_sample(longint'(x) + scale_q16(delayed, longint'(mix_gain_cfg)));
        echo_line[chan][wr] =
            clip_sample(longint'(x) + scale_q16(delayed, longint'(feedback_gain_cfg)));
        line_pos[chan] = (wr + 1) % MAX_DELAY;
        return wet;
    endfunction

    function automatic void note_failure(string msg);
        error_count++;
        $display("%0t ns: %s", $time, msg);
    endfunction

    function automatic logic signed [15:0] random_sample();
        case ($urandom_range(7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    // ------------------------------------------------------ result checker
    // Pops the oldest expectation on every output handshake.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_echo_q.size() == 0)
                note_failure($sformatf("unexpected result: expected none, actual %0d",
                                       out_sample));
            else
            begin
                expected_out = expected_echo_q.pop_front();
                if (out_sample !== expected_out)
                    note_failure($sformatf("out_sample mismatch: expected %0d, actual %0d",
                                           expected_out, out_sample));
                echoes_checked++;
            end
        end
    end

    // ------------------------------------------------------------ receiver
    // Random out_ready, or a long hold when a test asks for one.
    always @(posedge clk)
    begin
        if (hold_len > 0)
        begin
            stall_left = hold_len;
            hold_len   = 0;
        end
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // -------------------------------------------------------------- sender
    // Optional idle gap, then offer the request and hold it until taken.
    // in_valid stays high after the handshake so back-to-back requests
    // never see it dropped and raised in one step.
    task automatic send_request(logic signed [15:0] sample, logic chan);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_sample   <= sample;
        channel_sel <= chan;
        do
            @(posedge clk);
        while (!in_ready);
        expected_echo_q.push_back(predict_echo(sample, chan));
        requests_sent++;
    endtask

    // Stop offering, let every expected result arrive, then settle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_echo_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------ APB port
    // Setup, access, then idle with psel low so no signal gets two updates per step.
    task automatic apb_write(int idx, int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AW'(idx * 4);
        pwdata  <= DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        // writes past the last register are dropped
        if (idx == sfd_pkg::REG_MIX_GAIN)
            mix_gain_cfg = value[15:0];
        else if (idx == sfd_pkg::REG_FEEDBACK_GAIN)
            feedback_gain_cfg = value[15:0];
        else if (idx == sfd_pkg::REG_DELAY_SAMPLES)
            delay_cfg = value[15:0];
    endtask

    task automatic apb_read_check(int idx, int unsigned want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= AW'(idx * 4);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[15:0] !== want[15:0])
            note_failure($sformatf("register %0d readback: expected %0d, actual %0d",
                                   idx, want[15:0], prdata[15:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(int unsigned mix, int unsigned fb, int unsigned dly);
        apb_write(sfd_pkg::REG_MIX_GAIN, mix);
        apb_write(sfd_pkg::REG_FEEDBACK_GAIN, fb);
        apb_write(sfd_pkg::REG_DELAY_SAMPLES, dly);
    endtask

    // --------------------------------------------------------------- tests
    // Reset settings pass samples through; then exactly at the threshold.
    task automatic test_passthrough();
        send_request(16'sh8000, 1'b0);
        send_request(16'sh7fff, 1'b1);
        send_request(16'sh0000, 1'b0);
        send_request(-16'sd1, 1'b1);
        wait_drained();
        apply_settings(sfd_pkg::MIX_THRESHOLD, 65535, 1);
        send_request(16'sh7fff, 1'b0);
        send_request(16'sh8000, 1'b1);
        send_request(16'sd1, 1'b0);
        send_request(16'sd12345, 1'b1);
        wait_drained();
    endtask

    // Just above threshold, full-scale saturation, delay clamps, dead register.
    task automatic test_echo_directed();
        apply_settings(sfd_pkg::MIX_THRESHOLD + 1, 0, 1);
        send_request(16'sd1000, 1'b0);
        send_request(-16'sd2000, 1'b0);
        send_request(16'sd500, 1'b1);
        wait_drained();
        apply_settings(65535, 65535, 1);
        send_request(16'sh7fff, 1'b0);
        send_request(16'sh7fff, 1'b0);
        send_request(16'sh8000, 1'b1);
        send_request(16'sh8000, 1'b1);
        wait_drained();
        apply_settings(30000, 20000, 0);          // zero delay
        send_request(16'sd8000, 1'b0);
        send_request(16'sd8000, 1'b0);
        wait_drained();
        apply_settings(30000, 20000, 65535);      // beyond the line length
        send_request(-16'sd7000, 1'b1);
        send_request(16'sd100, 1'b1);
        wait_drained();
        apb_write(UNUSED_REG, 16'h1234);          // must change nothing
        send_request(16'sd3000, 1'b0);
        send_request(16'sd3000, 1'b0);
        wait_drained();
    endtask

    task automatic test_register_readback();
        apply_settings(16'hA5A5, 16'h5A5A, 16'hFFFF);
        apb_read_check(sfd_pkg::REG_MIX_GAIN, 16'hA5A5);
        apb_read_check(sfd_pkg::REG_FEEDBACK_GAIN, 16'h5A5A);
        apb_read_check(sfd_pkg::REG_DELAY_SAMPLES, 16'hFFFF);
        apply_settings(16'h5A5A, 16'hA5A5, 16'h0000);
        apb_read_check(sfd_pkg::REG_MIX_GAIN, 16'h5A5A);
        apb_read_check(sfd_pkg::REG_FEEDBACK_GAIN, 16'hA5A5);
        apb_read_check(sfd_pkg::REG_DELAY_SAMPLES, 16'h0000);
    endtask

    // Phases of random traffic; short delays mostly so echoes build up.
    task automatic test_random_echo();
        int phase;
        int unsigned mix;
        int unsigned dly;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase < 5)
            begin
                send_idle_pct = 32;
                recv_idle_pct = 67;
            end
            else if (phase < 10)
            begin
                send_idle_pct = 67;
                recv_idle_pct = 32;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (phase)
                0: apply_settings(65535, 65535, 1);
                1: apply_settings(sfd_pkg::MIX_THRESHOLD + 1, 0, 2);
                2: apply_settings(40000, 50000, 0);
                3: apply_settings(20000, 30000, MAX_DELAY);
                default:
                begin
                    mix = ($urandom_range(7) == 0) ? $urandom_range(sfd_pkg::MIX_THRESHOLD)
                                                   : $urandom_range(656, 65535);
                    dly = ($urandom_range(7) == 0) ? $urandom_range(65535)
                                                   : $urandom_range(1, 40);
                    apply_settings(mix, $urandom_range(65535), dly);
                end
            endcase
            repeat (PHASE_REQUESTS) send_request(random_sample(), 1'($urandom_range(1)));
            wait_drained();
        end
    endtask

    // Receiver holds off while the sender keeps offering: queue fills,
    // in_ready must drop, nothing may be lost.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_settings(50000, 40000, 3);
        hold_len = HOLD_CYCLES;
        repeat (60) send_request(random_sample(), 1'($urandom_range(1)));
        wait_drained();
    endtask

    // Full-length delay on both channels, alternating: each read lands on
    // the slot about to be overwritten.
    task automatic test_full_length_wrap();
        int i;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_settings(45000, 35000, MAX_DELAY);
        for (i = 0; i < FULL_REQUESTS; i++)
            send_request(random_sample(), 1'(i));
        wait_drained();
    endtask

    // ---------------------------------------------------------------- main
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_passthrough();
        test_echo_directed();
        test_register_readback();
        test_random_echo();
        test_backpressure();
        test_full_length_wrap();

        if (expected_echo_q.size() != 0)
            note_failure($sformatf("%0d results never arrived", expected_echo_q.size()));
        $display("Sent %0d sample requests: dry pass, threshold, saturation, delay clamps,",
                 requests_sent);
        $display("readback, full output queue and full-length delay; %0d results checked.",
                 echoes_checked);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial
    begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
